// ===== src/assert_macros.svh =====
// Assertion macros shared by the servo sweep controller RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held.
`define SSC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("servo sweep controller assertion failed");

// Condition in a cycle implies a property in the next.
`define SSC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    `SSC_ASSERT(label, clk, rst_n, (cond) |=> (prop))

`endif

// ===== src/ssc_pkg.sv =====
// Package for the servo sweep controller: word types, state, constants, codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_SET      = 3'd1;
    localparam logic [2:0] CMD_OVERRIDE = 3'd2;
    localparam logic [2:0] CMD_RELEASE  = 3'd3;
    localparam logic [2:0] CMD_TOGGLE   = 3'd4;
    localparam logic [2:0] CMD_INC      = 3'd5;
    localparam logic [2:0] CMD_DEC      = 3'd6;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELAY_PRESENT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_DETACH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DETACH_DELAY  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_STATE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_START  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_START     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_START     = 3'd7;

    localparam logic [7:0]  LIMIT_HIGH = 8'd160;
    localparam logic [7:0]  LIMIT_LOW  = 8'd20;
    localparam logic [7:0]  NUDGE      = 8'd2;
    localparam logic [8:0]  STEP_SAT   = 9'h1FF;
    localparam logic [10:0] IDLE_SAT   = 11'h7FF;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] position;
        logic       drive_engaged;
        logic       relay_level;
        logic       position_written;
    } res_word_t;

    typedef struct packed {
        logic [7:0] step_interval;
        logic       relay_present;
        logic       auto_detach;
        logic [9:0] detach_delay;
        logic       start_state;
        logic       relay_invert_start;
        logic [7:0] min_start;
        logic [7:0] max_start;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        step_interval:      8'd20,
        relay_present:      1'b1,
        auto_detach:        1'b1,
        detach_delay:       10'd500,
        start_state:        1'b0,
        relay_invert_start: 1'b0,
        min_start:          8'd90,
        max_start:          8'd90
    };

    typedef struct packed {
        logic [7:0]  current_position;
        logic [7:0]  previous_position;
        logic [7:0]  low_endpoint;
        logic [7:0]  high_endpoint;
        logic        switch_state;
        logic        override_active;
        logic [7:0]  override_target;
        logic        relay_invert;
        logic        relay_out;
        logic        engaged;
        logic        startup_pending;
        logic [8:0]  step_elapsed;
        logic [10:0] idle_elapsed;
    } state_t;

    // Configuration write as seen by the core: reload strobe and the full next configuration.
    typedef struct packed {
        logic reload;
        cfg_t cfg;
    } cfg_ctrl_t;

    function automatic state_t load_state(input cfg_t c);
        state_t s;
        s.low_endpoint      = c.min_start;
        s.high_endpoint     = c.max_start;
        s.switch_state      = c.start_state;
        s.current_position  = c.start_state ? c.max_start : c.min_start;
        s.previous_position = s.current_position;
        s.relay_invert      = c.relay_invert_start;
        s.override_active   = 1'b0;
        s.override_target   = 8'd0;
        s.relay_out         = 1'b0;
        s.engaged           = 1'b0;
        s.startup_pending   = 1'b1;
        s.step_elapsed      = 9'd0;
        s.idle_elapsed      = 11'd0;
        return s;
    endfunction

endpackage

// ===== src/ssc_cfg.sv =====
// Configuration register file of the servo sweep controller.
// Depends on ssc_pkg; flags a state reload when a start register is written.
`timescale 1ns / 1ps

module ssc_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ssc_pkg::cfg_ctrl_t                 ctrl
);
    import ssc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign wr = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (cfg_index)
                REG_STEP_INTERVAL: cfg_next.step_interval      = cfg_data[7:0];
                REG_RELAY_PRESENT: cfg_next.relay_present      = cfg_data[0];
                REG_AUTO_DETACH:   cfg_next.auto_detach        = cfg_data[0];
                REG_DETACH_DELAY:  cfg_next.detach_delay       = cfg_data[9:0];
                REG_START_STATE:   cfg_next.start_state        = cfg_data[0];
                REG_INVERT_START:  cfg_next.relay_invert_start = cfg_data[0];
                REG_MIN_START:     cfg_next.min_start          = cfg_data[7:0];
                REG_MAX_START:     cfg_next.max_start          = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hand the core the values that take effect at this edge.
    assign ctrl.reload = wr && (cfg_index inside {REG_START_STATE, REG_INVERT_START,
                                                  REG_MIN_START, REG_MAX_START});
    assign ctrl.cfg    = cfg_next;

endmodule

// ===== src/ssc_step.sv =====
// Per-word update logic of the servo sweep controller (combinational).
// Depends on ssc_pkg; maps state, configuration and one command to new state.
`timescale 1ns / 1ps

module ssc_step
(
    input  ssc_pkg::state_t    st,
    input  ssc_pkg::cfg_t      cfg,
    input  ssc_pkg::cmd_word_t word,
    output ssc_pkg::state_t    st_next,
    output ssc_pkg::res_word_t res
);
    import ssc_pkg::*;

    logic signed [8:0] diff;
    logic signed [8:0] diff_adj;
    logic signed [8:0] half;
    logic [7:0]        mid;
    logic [7:0]        setpoint;
    logic [7:0]        new_pos;
    logic [8:0]        se;
    logic [10:0]       ie;
    logic              written;

    // Midpoint with the halving truncated toward zero.
    assign diff     = $signed({1'b0, st.high_endpoint}) - $signed({1'b0, st.low_endpoint});
    assign diff_adj = diff + $signed({8'd0, diff[8]});
    assign half     = diff_adj >>> 1;
    assign mid      = half[7:0] + st.low_endpoint;

    assign setpoint = st.override_active ? st.override_target
                    : (st.switch_state ? st.high_endpoint : st.low_endpoint);

    always_comb
    begin
        if (st.current_position < setpoint)
        begin
            new_pos = st.current_position + 8'd1;
        end
        else if (st.current_position > setpoint)
        begin
            new_pos = st.current_position - 8'd1;
        end
        else
        begin
            new_pos = st.current_position;
        end
    end

    always_comb
    begin
        st_next = st;
        written = 1'b0;
        se      = (st.step_elapsed < STEP_SAT) ? st.step_elapsed + 9'd1 : st.step_elapsed;
        ie      = (st.idle_elapsed < IDLE_SAT) ? st.idle_elapsed + 11'd1 : st.idle_elapsed;
        case (word.command)
            CMD_TICK:
            begin
                st_next.step_elapsed = se;
                st_next.idle_elapsed = ie;
                if (se > {1'b0, cfg.step_interval})
                begin
                    st_next.step_elapsed = 9'd0;
                    if (cfg.relay_present)
                    begin
                        st_next.relay_out = (st.current_position < mid) ^ st.relay_invert;
                    end
                    st_next.current_position = new_pos;
                    if ((st.previous_position != new_pos) || st.startup_pending)
                    begin
                        st_next.previous_position = new_pos;
                        written                   = 1'b1;
                        st_next.idle_elapsed      = 11'd0;
                        if (((new_pos != setpoint) || st.startup_pending) && !st.engaged)
                        begin
                            st_next.engaged         = 1'b1;
                            st_next.startup_pending = 1'b0;
                        end
                    end
                end
                if (st_next.engaged && cfg.auto_detach &&
                    (st_next.idle_elapsed > {1'b0, cfg.detach_delay}))
                begin
                    st_next.engaged = 1'b0;
                end
            end
            CMD_SET:
            begin
                st_next.switch_state = |word.value;
            end
            CMD_OVERRIDE:
            begin
                st_next.override_target = word.value;
                st_next.override_active = 1'b1;
                st_next.idle_elapsed    = 11'd0;
            end
            CMD_RELEASE:
            begin
                st_next.override_active = 1'b0;
            end
            CMD_TOGGLE:
            begin
                st_next.relay_invert = ~st.relay_invert;
            end
            CMD_INC:
            begin
                if (st.switch_state && (st.high_endpoint <= LIMIT_HIGH))
                begin
                    st_next.high_endpoint = st.high_endpoint + NUDGE;
                end
                else if (st.low_endpoint <= LIMIT_HIGH)
                begin
                    st_next.low_endpoint = st.low_endpoint + NUDGE;
                end
            end
            CMD_DEC:
            begin
                if (st.switch_state && (st.high_endpoint >= LIMIT_LOW))
                begin
                    st_next.high_endpoint = st.high_endpoint - NUDGE;
                end
                else if (st.low_endpoint >= LIMIT_LOW)
                begin
                    st_next.low_endpoint = st.low_endpoint - NUDGE;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

    assign res.position         = st_next.current_position;
    assign res.drive_engaged    = st_next.engaged;
    assign res.relay_level      = st_next.relay_out;
    assign res.position_written = written;

endmodule

// ===== src/servo_sweep_controller_unit.sv =====
// Top level of the servo sweep controller: input register, state, result register.
// Depends on ssc_pkg, ssc_cfg, ssc_step and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   | Signals                                | Direction | Handshake
// ----------+----------------------------------------+-----------+---------------------
// command   | cmd_valid, cmd_stall, cmd_word         | in        | valid high, stall low
// result    | res_valid, res_stall, res_word         | out       | valid high, stall low
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in     | valid and ready high
//
// Flow: one word accepted per clock while cmd_stall is low; a result passes the
//   command register, then the result register. The state update is a single pass
//   of ssc_step between the two, so back-to-back words see each other's effects.
// Reset: rst_n is asynchronous, active low; registers take their documented reset
//   values and state loads from them at once, with no clearing pass.
// Stalls: a stalled result holds the command register, and cmd_stall rises only
//   when the command register is full and cannot move on.
// Configuration is taken only while the command register is empty.

module servo_sweep_controller_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  ssc_pkg::cmd_word_t               cmd_word,
    output logic                             res_valid,
    input  logic                             res_stall,
    output ssc_pkg::res_word_t               res_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ssc_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    cmd_word_t s1_word_reg;
    logic      res_valid_reg;
    logic      res_valid_next;
    res_word_t res_word_reg;
    state_t    state_reg;
    state_t    state_next;
    state_t    step_state;
    res_word_t step_res;
    cfg_ctrl_t cfg_ctrl;
    logic      s1_adv;
    logic      cmd_take;

    // Advance the command register whenever the result register is free or draining.
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = s1_valid_reg && !s1_adv;
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign cfg_ready = !s1_valid_reg;

    ssc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (cfg_ctrl)
    );

    // The configuration seen by the step logic equals the stored registers here,
    // since writes only land while the command register is empty.
    ssc_step u_step
    (
        .st      (state_reg),
        .cfg     (cfg_ctrl.cfg),
        .word    (s1_word_reg),
        .st_next (step_state),
        .res     (step_res)
    );

    assign s1_valid_next  = cmd_take || (s1_valid_reg && !s1_adv);
    assign res_valid_next = s1_adv || (res_valid_reg && res_stall);

    always_comb
    begin
        if (cfg_ctrl.reload)
        begin
            state_next = load_state(cfg_ctrl.cfg);
        end
        else if (s1_adv)
        begin
            state_next = step_state;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= load_state(CFG_RESET);
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: capture on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_word_reg <= cmd_word;
        end
        if (s1_adv)
        begin
            res_word_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // A word leaving the command register always lands in the result register.
    `SSC_ASSERT_NEXT(a_adv_lands, clk, rst_n, s1_adv, res_valid_reg)
    // Only ticks write a position.
    `SSC_ASSERT_NEXT(a_cmd_no_write, clk, rst_n,
        s1_adv && (s1_word_reg.command != CMD_TICK), !res_word_reg.position_written)
    // Only ticks move the position.
    `SSC_ASSERT_NEXT(a_cmd_pos_hold, clk, rst_n,
        s1_adv && (s1_word_reg.command != CMD_TICK), $stable(state_reg.current_position))
    // Drive engages only together with a position write.
    `SSC_ASSERT(a_engage_written, clk, rst_n,
        $rose(state_reg.engaged) |-> res_word_reg.position_written)

endmodule

// ===== sim/servo_sweep_controller_unit_tb.sv =====
// Self-checking bench for servo_sweep_controller_unit: command words in, result words out.
// Depends on ssc_pkg and the block's RTL; carries its own behavioural model of the block.
`timescale 1ns / 1ps

module servo_sweep_controller_unit_tb;

    import ssc_pkg::*;

    // The one command code that the block leaves without a name
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // Cycles with no word moving on any channel before the run is given up
    localparam int QUIET_LIMIT = 2000;

    // Number of random phases, each with its own register setting and idling mix
    localparam int N_PHASES = 5;

    // One line of the directed script: either a register write or a command word,
    // optionally with the result typed in by hand
    typedef struct packed {
        logic      is_reg;
        logic [2:0] code;
        logic [9:0] data;
        logic      typed;
        res_word_t want;
    } script_row_t;

    logic      clk;
    logic      rst_n = 1'b0;

    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd_word = '0;

    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res_word;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Model copy of the registers
    logic [7:0] set_interval;
    logic       set_relay;
    logic       set_detach;
    logic [9:0] set_delay;
    logic       set_start;
    logic       set_inv_start;
    logic [7:0] set_low_start;
    logic [7:0] set_high_start;

    // Model copy of the positioner state
    logic [7:0]  pos;
    logic [7:0]  prev_pos;
    logic [7:0]  low_ep;
    logic [7:0]  high_ep;
    logic        hi_state;
    logic        ovr_on;
    logic [7:0]  ovr_pos;
    logic        inv;
    logic        relay;
    logic        engaged;
    logic        startup;
    logic [8:0]  step_ms;
    logic [10:0] idle_ms;

    // Results still owed by the block, oldest first
    res_word_t   owed_results[$];
    res_word_t   head_result;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int quiet = 0;
    int n_words = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_reg = 0;

    script_row_t script[$];

    servo_sweep_controller_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------------------------
    // Model of the positioner
    // ---------------------------------------------------------------------------------

    // Reload every state bit from the start registers, as at reset
    task automatic reload_servo_state();
        low_ep   = set_low_start;
        high_ep  = set_high_start;
        hi_state = set_start;
        pos      = set_start ? set_high_start : set_low_start;
        prev_pos = pos;
        inv      = set_inv_start;
        ovr_on   = 1'b0;
        ovr_pos  = 8'd0;
        relay    = 1'b0;
        engaged  = 1'b0;
        startup  = 1'b1;
        step_ms  = '0;
        idle_ms  = '0;
    endtask

    task automatic apply_reg_write(input logic [2:0] idx, input logic [9:0] data);
        case (idx)
            REG_STEP_INTERVAL: set_interval = data[7:0];
            REG_RELAY_PRESENT: set_relay = data[0];
            REG_AUTO_DETACH:   set_detach = data[0];
            REG_DETACH_DELAY:  set_delay = data;
            REG_START_STATE:
            begin
                set_start = data[0];
                reload_servo_state();
            end
            REG_INVERT_START:
            begin
                set_inv_start = data[0];
                reload_servo_state();
            end
            REG_MIN_START:
            begin
                set_low_start = data[7:0];
                reload_servo_state();
            end
            REG_MAX_START:
            begin
                set_high_start = data[7:0];
                reload_servo_state();
            end
            default: ;
        endcase
    endtask

    // Advance the model by one command word and return the result word it yields
    function automatic res_word_t servo_result(input cmd_word_t w);
        res_word_t  r;
        logic [7:0] setpoint;
        logic [7:0] mid;
        int         span;
        logic       written;
        written = 1'b0;
        case (w.command)
            CMD_TICK:
            begin
                if (step_ms < STEP_SAT)
                    step_ms++;
                if (idle_ms < IDLE_SAT)
                    idle_ms++;
                if (step_ms > {1'b0, set_interval})
                begin
                    step_ms = '0;
                    // Midpoint truncates toward zero, so a low endpoint above the high
                    // one still lands between them
                    span = int'(high_ep) - int'(low_ep);
                    span = span / 2 + int'(low_ep);
                    mid  = span[7:0];
                    if (set_relay)
                        relay = (pos < mid) ^ inv;
                    setpoint = ovr_on ? ovr_pos : (hi_state ? high_ep : low_ep);
                    if (pos < setpoint)
                        pos++;
                    else if (pos > setpoint)
                        pos--;
                    if (prev_pos != pos || startup)
                    begin
                        prev_pos = pos;
                        written  = 1'b1;
                        idle_ms  = '0;
                        if ((pos != setpoint || startup) && !engaged)
                        begin
                            engaged = 1'b1;
                            startup = 1'b0;
                        end
                    end
                end
                if (engaged && set_detach && idle_ms > {1'b0, set_delay})
                    engaged = 1'b0;
            end
            CMD_SET:      hi_state = (w.value != 8'd0);
            CMD_OVERRIDE:
            begin
                ovr_pos = w.value;
                ovr_on  = 1'b1;
                idle_ms = '0;
            end
            CMD_RELEASE:  ovr_on = 1'b0;
            CMD_TOGGLE:   inv = ~inv;
            CMD_INC:
            begin
                // A high endpoint past its limit pushes the nudge onto the low one
                if (hi_state && high_ep <= LIMIT_HIGH)
                    high_ep += NUDGE;
                else if (low_ep <= LIMIT_HIGH)
                    low_ep += NUDGE;
            end
            CMD_DEC:
            begin
                if (hi_state && high_ep >= LIMIT_LOW)
                    high_ep -= NUDGE;
                else if (low_ep >= LIMIT_LOW)
                    low_ep -= NUDGE;
            end
            default: ;
        endcase
        r.position         = pos;
        r.drive_engaged    = engaged;
        r.relay_level      = relay;
        r.position_written = written;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // Script rows
    // ---------------------------------------------------------------------------------

    function automatic script_row_t cmd_row(input logic [2:0] code, input logic [7:0] value);
        script_row_t row;
        row        = '0;
        row.code   = code;
        row.data   = {2'b00, value};
        return row;
    endfunction

    function automatic script_row_t reg_row(input logic [2:0] idx, input logic [9:0] data);
        script_row_t row;
        row        = '0;
        row.is_reg = 1'b1;
        row.code   = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic script_row_t known_row(input logic [2:0] code, input logic [7:0] value,
                                              input logic [7:0] p, input logic eng,
                                              input logic rly, input logic wr);
        script_row_t row;
        row       = cmd_row(code, value);
        row.typed = 1'b1;
        row.want  = {p, eng, rly, wr};
        return row;
    endfunction

    // ---------------------------------------------------------------------------------
    // Channel drivers
    // ---------------------------------------------------------------------------------

    // Offer one command word, hold it until taken, then log what it should yield.
    // Valid stays high on return so that the next word can follow at once.
    task automatic send_word(input cmd_word_t w, input logic typed, input res_word_t want);
        res_word_t got;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        got = servo_result(w);
        owed_results.push_back(typed ? want : got);
        n_words++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    task automatic drain();
        cmd_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg_write(idx, data);
        cfg_valid <= 1'b0;
        n_reg++;
    endtask

    task automatic apply_setup(input logic [9:0] interval, input logic [9:0] relay_en,
                               input logic [9:0] detach_en, input logic [9:0] delay,
                               input logic [9:0] start, input logic [9:0] inv_start,
                               input logic [9:0] low_start, input logic [9:0] high_start);
        write_reg(REG_STEP_INTERVAL, interval);
        write_reg(REG_RELAY_PRESENT, relay_en);
        write_reg(REG_AUTO_DETACH, detach_en);
        write_reg(REG_DETACH_DELAY, delay);
        write_reg(REG_START_STATE, start);
        write_reg(REG_INVERT_START, inv_start);
        write_reg(REG_MIN_START, low_start);
        write_reg(REG_MAX_START, high_start);
    endtask

    // ---------------------------------------------------------------------------------
    // Result checker and receiver stalls
    // ---------------------------------------------------------------------------------

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && res_valid && !res_stall)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result word %h arrived with nothing outstanding", res_word);
                errors++;
            end
            else
            begin
                head_result = owed_results.pop_front();
                n_checked++;
                if (res_word.position_written)
                    n_writes++;
                if (res_word.position !== head_result.position)
                begin
                    $error("position: expected %0d, got %0d",
                           head_result.position, res_word.position);
                    errors++;
                end
                if (res_word.drive_engaged !== head_result.drive_engaged)
                begin
                    $error("drive_engaged: expected %b, got %b",
                           head_result.drive_engaged, res_word.drive_engaged);
                    errors++;
                end
                if (res_word.relay_level !== head_result.relay_level)
                begin
                    $error("relay_level: expected %b, got %b",
                           head_result.relay_level, res_word.relay_level);
                    errors++;
                end
                if (res_word.position_written !== head_result.position_written)
                begin
                    $error("position_written: expected %b, got %b",
                           head_result.position_written, res_word.position_written);
                    errors++;
                end
            end
        end
    end

    // Watchdog: give up once no word has moved on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
            $display("servo_sweep_controller_unit verification failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ---------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------

    initial
    begin
        cmd_word_t   w;
        script_row_t row;
        int          items;
        int          tick_pct;
        int          ph;

        // Model registers at their reset values
        set_interval   = 8'd20;
        set_relay      = 1'b1;
        set_detach     = 1'b1;
        set_delay      = 10'd500;
        set_start      = 1'b0;
        set_inv_start  = 1'b0;
        set_low_start  = 8'd90;
        set_high_start = 8'd90;
        reload_servo_state();

        // Directed script. Rows typed in by hand cover the reset state, the first
        // step after reset and the state right after a reload.
        script.push_back(known_row(CMD_SET, 8'h00, 8'd90, 1'b0, 1'b0, 1'b0));
        script.push_back(known_row(CMD_UNUSED, 8'hFF, 8'd90, 1'b0, 1'b0, 1'b0));
        script.push_back(known_row(CMD_TICK, 8'h00, 8'd90, 1'b0, 1'b0, 1'b0));
        script.push_back(reg_row(REG_STEP_INTERVAL, 10'd0));
        // First step engages the drive and writes the position even with no move
        script.push_back(known_row(CMD_TICK, 8'h00, 8'd90, 1'b1, 1'b0, 1'b1));
        script.push_back(known_row(CMD_TICK, 8'h00, 8'd90, 1'b1, 1'b0, 1'b0));
        script.push_back(cmd_row(CMD_OVERRIDE, 8'hFF));
        script.push_back(cmd_row(CMD_TICK, 8'h00));
        script.push_back(cmd_row(CMD_TOGGLE, 8'h00));
        script.push_back(cmd_row(CMD_TICK, 8'hFF));
        script.push_back(cmd_row(CMD_RELEASE, 8'h00));
        // Any nonzero value selects the high state
        script.push_back(cmd_row(CMD_SET, 8'h80));
        script.push_back(cmd_row(CMD_INC, 8'h00));
        script.push_back(cmd_row(CMD_DEC, 8'h00));
        // Relay absent: level holds; upper data bits are don't-care
        script.push_back(reg_row(REG_RELAY_PRESENT, 10'h3FE));
        script.push_back(cmd_row(CMD_OVERRIDE, 8'h00));
        script.push_back(cmd_row(CMD_TICK, 8'h00));
        script.push_back(reg_row(REG_DETACH_DELAY, 10'd0));
        script.push_back(cmd_row(CMD_TICK, 8'h00));
        // Start register writes reload the whole state
        script.push_back(reg_row(REG_MIN_START, 10'h0FF));
        script.push_back(known_row(CMD_SET, 8'h01, 8'd255, 1'b0, 1'b0, 1'b0));
        script.push_back(reg_row(REG_MAX_START, 10'h0FF));
        script.push_back(known_row(CMD_SET, 8'h01, 8'd255, 1'b0, 1'b0, 1'b0));
        // Both endpoints past the upper limit: increment changes nothing
        script.push_back(known_row(CMD_INC, 8'h00, 8'd255, 1'b0, 1'b0, 1'b0));
        script.push_back(cmd_row(CMD_DEC, 8'h00));
        script.push_back(reg_row(REG_MAX_START, 10'h000));
        script.push_back(known_row(CMD_SET, 8'h01, 8'd255, 1'b0, 1'b0, 1'b0));
        // High endpoint below the lower limit: decrement moves the low one instead
        script.push_back(cmd_row(CMD_DEC, 8'h00));
        script.push_back(cmd_row(CMD_INC, 8'h00));
        script.push_back(reg_row(REG_RELAY_PRESENT, 10'd1));
        script.push_back(cmd_row(CMD_TICK, 8'h00));
        script.push_back(reg_row(REG_START_STATE, 10'h001));
        script.push_back(reg_row(REG_INVERT_START, 10'h001));
        script.push_back(known_row(CMD_TOGGLE, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0));
        script.push_back(cmd_row(CMD_TICK, 8'h00));

        // Hold reset low, then release it on a clock edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the script with no idling on either side
        foreach (script[i])
        begin
            row = script[i];
            if (row.is_reg)
            begin
                drain();
                write_reg(row.code, row.data);
            end
            else
            begin
                w.command = row.code;
                w.value   = row.data[7:0];
                send_word(w, row.typed, row.want);
            end
        end

        // Random phases: each one drains, rewrites every register, then streams words.
        // Short step intervals keep the servo moving; the last phase sits at the
        // register extremes with almost nothing but ticks.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            items    = 100;
            tick_pct = 75;
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    apply_setup(10'($urandom_range(2)), 10'd1, 10'd1,
                                10'($urandom_range(40)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                10'($urandom_range(255)), 10'($urandom_range(255)));
                end
                1:
                begin
                    send_idle_pct = 86;
                    stall_pct     = 0;
                    apply_setup(10'($urandom_range(6)), 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(100)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                10'($urandom_range(255)), 10'($urandom_range(255)));
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 86;
                    apply_setup(10'($urandom_range(4)), 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(60)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                10'($urandom_range(255)), 10'($urandom_range(255)));
                end
                3:
                begin
                    send_idle_pct = 7;
                    stall_pct     = 7;
                    apply_setup(10'($urandom_range(3)), 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                10'($urandom_range(1023)), 10'($urandom_range(1023)),
                                10'($urandom_range(255)), 10'($urandom_range(255)));
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    items         = 260;
                    tick_pct      = 97;
                    apply_setup(10'd255, 10'd1, 10'd1, 10'd1023,
                                10'($urandom_range(1)), 10'($urandom_range(1)),
                                10'd0, 10'd255);
                end
            endcase

            repeat (items)
            begin
                if ($urandom_range(99) < tick_pct)
                    w.command = CMD_TICK;
                else
                    w.command = 3'($urandom_range(7, 1));
                w.value = 8'($urandom_range(255));
                // Mostly clean state bits, with the odd wide value
                if (w.command == CMD_SET && $urandom_range(3) != 0)
                    w.value = 8'($urandom_range(1));
                send_word(w, 1'b0, '0);
            end
        end

        drain();

        $display("run covered %0d command words and %0d register writes in %0d phases",
                 n_words, n_reg, N_PHASES + 1);
        $display("%0d result words checked, %0d of them servo position writes",
                 n_checked, n_writes);
        if (errors == 0)
            $display("servo_sweep_controller_unit verification clean");
        else
            $display("servo_sweep_controller_unit verification failed");
        $finish;
    end

endmodule
